// ===== hdl/rca_pkg.sv =====
// ----------------------------------------------------------------------------
// rca_pkg
// Shared types and codes for the rolling-code authenticator with lockout.
// ----------------------------------------------------------------------------
package rca_pkg;

   localparam int FACTOR_W = 32;
   localparam int DAY_W    = 5;
   localparam int KIND_W   = 3;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 8;
   localparam int TIMER_W  = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   // item kinds
   localparam logic [KIND_W-1:0] KIND_ATTEMPT = 3'd0;
   localparam logic [KIND_W-1:0] KIND_INIT    = 3'd1;
   localparam logic [KIND_W-1:0] KIND_BACKUP  = 3'd2;
   localparam logic [KIND_W-1:0] KIND_TICK    = 3'd3;
   localparam logic [KIND_W-1:0] KIND_KEEP    = 3'd4;

   // result status
   localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_BLOCKED  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_MISMATCH = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_FAIL_LIMIT  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_AUTH_WINDOW = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_KEEP_WINDOW = 2'd2;

   // reset values
   localparam logic [COUNT_W-1:0] RESET_FAIL_LIMIT = 8'd20;
   localparam logic [TIMER_W-1:0] RESET_WINDOW     = 16'd1440;

   typedef struct packed {
      logic [KIND_W-1:0]   kind;
      logic [FACTOR_W-1:0] factor;
      logic [DAY_W-1:0]    day;
   } rca_item_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic                limited;
      logic                attempts_allowed;
   } rca_result_type;

   typedef struct packed {
      logic [COUNT_W-1:0] fail_limit;
      logic [TIMER_W-1:0] auth_window;
      logic [TIMER_W-1:0] keep_window;
   } rca_cfg_type;

endpackage

// ===== hdl/rca_match.sv =====
// ----------------------------------------------------------------------------
// rca_match
// Parallel compare of a presented factor against the successors of the current and backup factors.
// ----------------------------------------------------------------------------
module rca_match
   import rca_pkg::*;
#(
   parameter int BACKUP_SLOTS = 3
) (
   input  logic [FACTOR_W-1:0]     factor,
   input  logic [FACTOR_W-1:0]     current_factor,
   input  logic [FACTOR_W-1:0]     backup [BACKUP_SLOTS],
   input  logic [BACKUP_SLOTS-1:0] backup_valid,
   output logic                    match
);

   logic [BACKUP_SLOTS-1:0] hit;

   always_comb begin
      for (int i = 0; i < BACKUP_SLOTS; i++) begin
         hit[i] = backup_valid[i] && ((backup[i] + 32'd1) == factor);
      end
   end

   assign match = ((current_factor + 32'd1) == factor) || (|hit);

endmodule

// ===== hdl/rca_core.sv =====
// ----------------------------------------------------------------------------
// rca_core
// Authenticator state and single-pass next-state logic for one item.
// ----------------------------------------------------------------------------
module rca_core
   import rca_pkg::*;
#(
   parameter int BACKUP_SLOTS = 3
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           advance,
   input  rca_item_type   item,
   input  rca_cfg_type    cfg,
   output rca_result_type result
);

   localparam int SLOT_W = $clog2(BACKUP_SLOTS + 1);
   localparam logic [SLOT_W-1:0] SLOT_NONE = SLOT_W'(BACKUP_SLOTS);
   localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(BACKUP_SLOTS - 1);

   logic [FACTOR_W-1:0] current_ff, current_in;
   logic [FACTOR_W-1:0] backup_ff [BACKUP_SLOTS];
   logic                full_ff, full_in;
   logic [SLOT_W-1:0]   slot_ff, slot_in;
   logic [COUNT_W-1:0]  errors_ff, errors_in;
   logic [TIMER_W-1:0]  window_ff, window_in;
   logic [TIMER_W-1:0]  keep_ff, keep_in;
   logic                allow_ff, allow_in;
   logic                limit_ff, limit_in;
   logic [DAY_W-1:0]    day_ff, day_in;

   logic [BACKUP_SLOTS-1:0] backup_valid;
   logic                    match;
   logic [SLOT_W-1:0]       next_slot;
   logic                    backup_write;
   logic [COUNT_W-1:0]      errors_inc;
   logic [STATUS_W-1:0]     status;

   // slots up to the last written one are live, all of them once wrapped
   always_comb begin
      for (int i = 0; i < BACKUP_SLOTS; i++) begin
         backup_valid[i] = full_ff ||
                           ((slot_ff != SLOT_NONE) && (SLOT_W'(i) <= slot_ff));
      end
   end

   rca_match #(
      .BACKUP_SLOTS(BACKUP_SLOTS)
   ) u_match (
      .factor         (item.factor),
      .current_factor (current_ff),
      .backup         (backup_ff),
      .backup_valid   (backup_valid),
      .match          (match)
   );

   assign next_slot  = ((slot_ff == SLOT_NONE) || (slot_ff == SLOT_LAST)) ?
                       '0 : slot_ff + 1'b1;
   assign errors_inc = errors_ff + 1'b1;

   always_comb begin
      current_in   = current_ff;
      full_in      = full_ff;
      slot_in      = slot_ff;
      errors_in    = errors_ff;
      window_in    = window_ff;
      keep_in      = keep_ff;
      allow_in     = allow_ff;
      limit_in     = limit_ff;
      day_in       = day_ff;
      backup_write = 1'b0;
      status       = STATUS_OK;

      case (item.kind)
         KIND_ATTEMPT: begin
            if (!allow_ff) begin
               status = STATUS_BLOCKED;
            end else if (match) begin
               current_in = item.factor;
               limit_in   = 1'b0;
               errors_in  = '0;
               window_in  = cfg.auth_window;
            end else begin
               status = STATUS_MISMATCH;
               if (errors_inc >= cfg.fail_limit) begin
                  errors_in = '0;
                  limit_in  = 1'b1;
                  if (keep_ff == '0) begin
                     allow_in = 1'b0;
                  end
               end else begin
                  errors_in = errors_inc;
               end
            end
         end
         KIND_INIT: begin
            current_in = item.factor;
            errors_in  = '0;
            allow_in   = 1'b1;
            limit_in   = 1'b0;
            full_in    = 1'b0;
            slot_in    = SLOT_NONE;
            window_in  = cfg.auth_window;
         end
         KIND_BACKUP: begin
            backup_write = 1'b1;
            slot_in      = next_slot;
            if (slot_ff == SLOT_LAST) begin
               full_in = 1'b1;
            end
         end
         KIND_TICK: begin
            if (window_ff != '0) begin
               window_in = window_ff - 1'b1;
            end else begin
               limit_in = 1'b1;
            end
            if (keep_ff != '0) begin
               keep_in = keep_ff - 1'b1;
            end
            if (day_ff != item.day) begin
               day_in = item.day;
               if (!allow_ff) begin
                  allow_in  = 1'b1;
                  errors_in = '0;
               end
            end
         end
         KIND_KEEP: begin
            keep_in   = cfg.keep_window;
            window_in = '0;
         end
         default: begin
            status = STATUS_BLOCKED;
         end
      endcase
   end

   assign result.status           = status;
   assign result.limited          = limit_in;
   assign result.attempts_allowed = allow_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         current_ff <= '0;
         full_ff    <= 1'b0;
         slot_ff    <= SLOT_NONE;
         errors_ff  <= '0;
         window_ff  <= RESET_WINDOW;
         keep_ff    <= '0;
         allow_ff   <= 1'b1;
         limit_ff   <= 1'b0;
         day_ff     <= '0;
      end else if (advance) begin
         current_ff <= current_in;
         full_ff    <= full_in;
         slot_ff    <= slot_in;
         errors_ff  <= errors_in;
         window_ff  <= window_in;
         keep_ff    <= keep_in;
         allow_ff   <= allow_in;
         limit_ff   <= limit_in;
         day_ff     <= day_in;
      end
   end

   // backup ring, no reset: entries are only read once written
   always_ff @(posedge clock) begin
      for (int i = 0; i < BACKUP_SLOTS; i++) begin
         if (advance && backup_write && (next_slot == SLOT_W'(i))) begin
            backup_ff[i] <= item.factor;
         end
      end
   end

endmodule

// ===== hdl/rolling_code_auth_lockout_top.sv =====
// ----------------------------------------------------------------------------
// rolling_code_auth_lockout_top
// Rolling-counter authenticator with failure lockout, keep grant and timers.
// ----------------------------------------------------------------------------
// Flow: an accepted request loads the input register; the result register is
//   loaded from the single-pass update when the item advances into the core.
// Throughput: one item per cycle while the response channel is not stalled.
// Reset: synchronous, active high; clears both stages, loads the register
//   defaults and the authenticator's reset state. No clearing pass is needed.
// ----------------------------------------------------------------------------
module rolling_code_auth_lockout_top
   import rca_pkg::*;
#(
   parameter int BACKUP_SLOTS = 3
) (
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [KIND_W-1:0]     req_kind,
   input  logic [FACTOR_W-1:0]   req_factor,
   input  logic [DAY_W-1:0]      req_day,
   // response channel
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [STATUS_W-1:0]   rsp_status,
   output logic                  rsp_limited,
   output logic                  rsp_attempts_allowed,
   // register write port
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   rca_cfg_type    cfg_ff;
   rca_item_type   item_ff;
   logic           in_valid_ff;
   rca_result_type rsp_ff;
   logic           rsp_valid_ff;
   rca_result_type result;
   logic           advance;

   // --- configuration registers; writes beyond the list are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.fail_limit  <= RESET_FAIL_LIMIT;
         cfg_ff.auth_window <= RESET_WINDOW;
         cfg_ff.keep_window <= RESET_WINDOW;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_FAIL_LIMIT:  cfg_ff.fail_limit  <= csr_wdata[COUNT_W-1:0];
            CSR_AUTH_WINDOW: cfg_ff.auth_window <= csr_wdata;
            CSR_KEEP_WINDOW: cfg_ff.keep_window <= csr_wdata;
            default: ;
         endcase
      end
   end

   // --- pipeline control
   // The held item moves into the core when the result register is free
   // or being emptied this cycle. The input register refills as it drains,
   // so a waiting result still leaves room for one more item.
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // --- payload registers
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff.kind   <= req_kind;
         item_ff.factor <= req_factor;
         item_ff.day    <= req_day;
      end
      if (advance) begin
         rsp_ff <= result;
      end
   end

   // --- authenticator state and update
   rca_core #(
      .BACKUP_SLOTS(BACKUP_SLOTS)
   ) u_core (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (item_ff),
      .cfg     (cfg_ff),
      .result  (result)
   );

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_status           = rsp_ff.status;
   assign rsp_limited          = rsp_ff.limited;
   assign rsp_attempts_allowed = rsp_ff.attempts_allowed;

endmodule

// ===== hdl/rca_checker.sv =====
// ----------------------------------------------------------------------------
// rca_checker
// Port-level checks for the authenticator, bound to the top level.
// ----------------------------------------------------------------------------
module rca_checker
   import rca_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                req_ready,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic [STATUS_W-1:0] rsp_status,
   input logic                rsp_limited,
   input logic                rsp_attempts_allowed
);

   // a pending response holds until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status))
      else $error("response dropped or changed while stalled");

   // status code 3 is never produced
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status != 2'd3)
      else $error("illegal status code");

   // allow is only cleared together with the limit flag
   a_mismatch_allowed: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STATUS_MISMATCH) && !rsp_limited
      |-> rsp_attempts_allowed)
      else $error("attempts blocked without limit on mismatch");

   // reset empties the pipeline
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("pipeline not empty after reset");

endmodule

bind rolling_code_auth_lockout_top rca_checker u_rca_checker (.*);
